FILE: src/pdq_pkg.sv
package pdq_pkg;

  localparam int SIZE_W    = 16;
  localparam int TIME_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SET_PROC   = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

FILE: src/pdq_req_if.sv
interface pdq_req_if import pdq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [SIZE_W-1:0] pkt_size;
  logic [TIME_W-1:0] pkt_time;
  logic [31:0]       processed_value;

  modport source (output valid, op, pkt_size, pkt_time, processed_value, input ready);
  modport sink   (input valid, op, pkt_size, pkt_time, processed_value, output ready);
endinterface

FILE: src/pdq_rsp_if.sv
interface pdq_rsp_if import pdq_pkg::*; #(
  parameter int LEN_W = 7,
  parameter int OCC_W = 22
);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SIZE_W-1:0] popped_size;
  logic [TIME_W-1:0] popped_time;
  logic [LEN_W-1:0]  length;
  logic [OCC_W-1:0]  occupancy;
  logic              is_empty;
  logic [SIZE_W-1:0] head_size;
  logic [TIME_W-1:0] head_time;
  logic [SIZE_W-1:0] tail_size;
  logic [TIME_W-1:0] tail_time;
  logic [31:0]       processed_count;

  modport source (output valid, status, popped_size, popped_time, length, occupancy,
                  is_empty, head_size, head_time, tail_size, tail_time,
                  processed_count, input ready);
  modport sink   (input valid, status, popped_size, popped_time, length, occupancy,
                  is_empty, head_size, head_time, tail_size, tail_time,
                  processed_count, output ready);
endinterface

FILE: src/packet_deque_with_byte_occupancy_core.sv
// Ch  | Role   | Payload
// req | sink   | op, pkt_size, pkt_time, processed_value
// rsp | source | status, popped_*, length, occupancy, is_empty, head_*, tail_*, processed_count
//
// Push, set processed, query and a pop that empties the queue load the result
// register directly. A pop that leaves entries behind first passes through S_READ:
// the new head or tail entry comes from the entry RAM, whose read port is registered.
// Reset (rst, synchronous) empties the queue and clears the processed count; the
// RAM contents are not cleared, only held entries are ever read.
// A new operation is taken only once the result register is free or being
// transferred in the same cycle, so a stalled rsp stalls req.
module packet_deque_with_byte_occupancy_core import pdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pdq_req_if.sink   req,
  pdq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int OCC_W = $clog2(DEPTH * (2 ** SIZE_W - 1) + 1);

  // Queue state: indexes of both ends, cached end entries, counters.
  state_t            state, state_next;
  logic [IDX_W-1:0]  head_idx, head_idx_next;
  logic [IDX_W-1:0]  tail_idx, tail_idx_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [31:0]       proc_cnt, proc_cnt_next;
  entry_t            head_ent, head_ent_next;
  entry_t            tail_ent, tail_ent_next;
  logic              rd_front;

  // Result register.
  logic              out_valid;
  status_t           out_status;
  entry_t            out_popped;
  entry_t            out_head;
  entry_t            out_tail;

  // Per-operation controls.
  logic              accept;
  status_t           status;
  entry_t            popped;
  entry_t            push_ent;
  logic              need_rd;
  logic              need_rd_front;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  logic              is_full;
  logic              is_nonempty;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  pdq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (push_ent),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Control: take a transfer only when idle and the result slot frees up.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        if (accept && need_rd) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept      = req.valid && req.ready;
  assign is_full     = (count == LEN_W'(DEPTH));
  assign is_nonempty = (count != '0);
  assign push_ent    = '{size: req.pkt_size, stamp: req.pkt_time};

  // Datapath: next queue state for the operation on req.
  always_comb begin
    head_idx_next = head_idx;
    tail_idx_next = tail_idx;
    count_next    = count;
    occ_next      = occ;
    proc_cnt_next = proc_cnt;
    head_ent_next = head_ent;
    tail_ent_next = tail_ent;
    status        = ST_OK;
    popped        = '0;
    need_rd       = 1'b0;
    need_rd_front = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_inc(tail_idx);
    rd_addr       = idx_inc(head_idx);
    case (op_t'(req.op))
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          wr_en      = accept;
          count_next = count + 1'b1;
          occ_next   = occ + OCC_W'(req.pkt_size);
          if (op_t'(req.op) == OP_PUSH_BACK) begin
            tail_idx_next = idx_inc(tail_idx);
            wr_addr       = idx_inc(tail_idx);
            tail_ent_next = push_ent;
            if (!is_nonempty) begin
              head_ent_next = push_ent;
            end
          end else begin
            head_idx_next = idx_dec(head_idx);
            wr_addr       = idx_dec(head_idx);
            head_ent_next = push_ent;
            if (!is_nonempty) begin
              tail_ent_next = push_ent;
            end
          end
        end
      end
      OP_POP_FRONT: begin
        if (!is_nonempty) begin
          status = ST_EMPTY;
        end else begin
          popped        = head_ent;
          head_idx_next = idx_inc(head_idx);
          proc_cnt_next = proc_cnt + 1'b1;
          count_next    = count - 1'b1;
          occ_next      = occ - OCC_W'(head_ent.size);
          rd_addr       = idx_inc(head_idx);
          need_rd       = (count != LEN_W'(1));
          need_rd_front = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (!is_nonempty) begin
          status = ST_EMPTY;
        end else begin
          popped        = tail_ent;
          tail_idx_next = idx_dec(tail_idx);
          count_next    = count - 1'b1;
          occ_next      = occ - OCC_W'(tail_ent.size);
          rd_addr       = idx_dec(tail_idx);
          need_rd       = (count != LEN_W'(1));
        end
      end
      OP_SET_PROC: begin
        proc_cnt_next = req.processed_value;
      end
      default: begin
        // Query and unused codes change nothing.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head_idx <= '0;
      tail_idx <= IDX_W'(DEPTH - 1);
      count    <= '0;
      occ      <= '0;
      proc_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        head_idx <= head_idx_next;
        tail_idx <= tail_idx_next;
        count    <= count_next;
        occ      <= occ_next;
        proc_cnt <= proc_cnt_next;
      end
    end
  end

  // Cached end entries and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_ent   <= head_ent_next;
      tail_ent   <= tail_ent_next;
      rd_front   <= need_rd_front;
      out_status <= status;
      out_popped <= popped;
      out_head   <= (count_next != '0) ? head_ent_next : '0;
      out_tail   <= (count_next != '0) ? tail_ent_next : '0;
    end else if (state == S_READ) begin
      // Fill in the end that moved from the RAM read.
      if (rd_front) begin
        head_ent <= rd_data;
        out_head <= rd_data;
      end else begin
        tail_ent <= rd_data;
        out_tail <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= !need_rd;
    end else if (state == S_READ) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.popped_size     = out_popped.size;
  assign rsp.popped_time     = out_popped.stamp;
  assign rsp.length          = count;
  assign rsp.occupancy       = occ;
  assign rsp.is_empty        = (count == '0);
  assign rsp.head_size       = out_head.size;
  assign rsp.head_time       = out_head.stamp;
  assign rsp.tail_size       = out_tail.size;
  assign rsp.tail_time       = out_tail.stamp;
  assign rsp.processed_count = proc_cnt;

endmodule

FILE: src/pdq_ram.sv
module pdq_ram import pdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/pdq_occupancy_checker.sv
`timescale 1ns / 100ps

module pdq_occupancy_checker import pdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  pdq_req_if   req,
  pdq_rsp_if   rsp,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic [1:0]        status;
    logic [SIZE_W-1:0] popped_size;
    logic [TIME_W-1:0] popped_time;
    logic [6:0]        length;
    logic [21:0]       occupancy;
    logic              is_empty;
    logic [SIZE_W-1:0] head_size;
    logic [TIME_W-1:0] head_time;
    logic [SIZE_W-1:0] tail_size;
    logic [TIME_W-1:0] tail_time;
    logic [31:0]       processed_count;
  } deque_report_t;

  // Shadow deque, front at index 0.
  entry_t        held[$];
  logic [22:0]   byte_sum;
  logic [31:0]   front_pops;
  deque_report_t expected_reports[$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    byte_sum       = '0;
    front_pops     = '0;
  end

  function deque_report_t apply_deque_op(input logic [2:0]        code,
                                         input logic [SIZE_W-1:0] nbytes,
                                         input logic [TIME_W-1:0] stamp,
                                         input logic [31:0]       new_count);
    deque_report_t r;
    entry_t        e;
    r        = '0;
    r.status = ST_OK;
    case (code)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held.size() >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          e.size  = nbytes;
          e.stamp = stamp;
          if (code == OP_PUSH_BACK) held.insert(held.size(), e);
          else held.insert(0, e);
          byte_sum = byte_sum + nbytes;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (code == OP_POP_FRONT) begin
            e = held[0];
            held.delete(0);
            front_pops = front_pops + 32'd1;
          end else begin
            e = held[$];
            held.delete(held.size() - 1);
          end
          r.popped_size = e.size;
          r.popped_time = e.stamp;
          byte_sum      = byte_sum - e.size;
        end
      end
      OP_SET_PROC: front_pops = new_count;
      default: ;
    endcase
    r.length          = 7'(held.size());
    r.occupancy       = byte_sum[21:0];
    r.is_empty        = (held.size() == 0);
    r.processed_count = front_pops;
    if (held.size() != 0) begin
      r.head_size = held[0].size;
      r.head_time = held[0].stamp;
      r.tail_size = held[$].size;
      r.tail_time = held[$].stamp;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want)
      flag_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  always @(posedge clk) begin
    deque_report_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result transfer with no expectation pending");
        end else begin
          want = expected_reports[0];
          expected_reports.delete(0);
          compare_field("status", 32'(want.status), 32'(rsp.status));
          compare_field("popped_size", 32'(want.popped_size), 32'(rsp.popped_size));
          compare_field("popped_time", want.popped_time, rsp.popped_time);
          compare_field("length", 32'(want.length), 32'(rsp.length));
          compare_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
          compare_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          compare_field("head_size", 32'(want.head_size), 32'(rsp.head_size));
          compare_field("head_time", want.head_time, rsp.head_time);
          compare_field("tail_size", 32'(want.tail_size), 32'(rsp.tail_size));
          compare_field("tail_time", want.tail_time, rsp.tail_time);
          compare_field("processed_count", want.processed_count, rsp.processed_count);
        end
      end
      if (req.valid && req.ready)
        expected_reports.insert(expected_reports.size(),
                                apply_deque_op(req.op, req.pkt_size, req.pkt_time,
                                               req.processed_value));
      outstanding = expected_reports.size();
    end
  end

endmodule

FILE: verif/tb_packet_deque_with_byte_occupancy_core.sv
`timescale 1ns / 100ps

module tb_packet_deque_with_byte_occupancy_core import pdq_pkg::*;;

  // Opcodes outside the defined set; the block must treat them as a query.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS      = 1430;
  localparam int FILL_ITEMS        = 70;      // more than DEPTH, so pushes hit a full queue
  localparam int MIDRUN_DRAIN_AT   = 700;
  localparam int LONG_STALL_AT     = 500;     // result transfers before the long hold-off
  localparam int LONG_STALL_CYCLES = 250;
  localparam int SETTLE_CYCLES     = 8;
  localparam int RUN_LIMIT_NS      = 5_000_000;

  typedef enum int {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIXED
  } seg_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_count;
  int   outstanding;
  bit   tx_idle;

  pdq_req_if req_ch ();
  pdq_rsp_if rsp_ch ();

  packet_deque_with_byte_occupancy_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // The checker sees every transfer on both channels, mirrors the deque and
  // compares each result against its prediction.
  pdq_occupancy_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one operation: idle for a random gap, then hold valid until the
  // block takes the transfer. Fields change only at the falling edge.
  task automatic offer(input logic [2:0] code, input logic [SIZE_W-1:0] nbytes,
                       input logic [TIME_W-1:0] stamp, input logic [31:0] new_count);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid           = 1'b1;
    req_ch.op              = code;
    req_ch.pkt_size        = nbytes;
    req_ch.pkt_time        = stamp;
    req_ch.processed_value = new_count;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Drop valid and hold the sender until every expected result has arrived.
  task automatic drain_all();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (outstanding == 0);
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic [2:0] any_misc();
    case ($urandom_range(0, 3))
      0:       return OP_SET_PROC;
      1:       return OP_SPARE_6;
      2:       return OP_SPARE_7;
      default: return OP_QUERY;
    endcase
  endfunction

  // Weight the opcode mix by segment: fill segments drive the queue toward
  // full, drain segments toward empty and into pops on empty.
  function automatic logic [2:0] pick_op(input seg_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      SEG_FILL:  return (roll < 85) ? any_push() : (roll < 95) ? any_pop() : any_misc();
      SEG_DRAIN: return (roll < 85) ? any_pop() : (roll < 95) ? any_push() : any_misc();
      default:   return (roll < 40) ? any_push() : (roll < 80) ? any_pop() : any_misc();
    endcase
  endfunction

  // Heavy segments favor maximum-size packets to push occupancy to its top.
  function automatic logic [SIZE_W-1:0] pick_size(input bit heavy);
    if (heavy && $urandom_range(0, 3) != 0) return '1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Bias the processed value toward the wrap point now and then.
  function automatic logic [31:0] pick_count();
    if ($urandom_range(0, 3) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Result side: wait a random gap per result, then hold ready until the
  // transfer. Once, hold ready low for a long stretch so the result register
  // backs up and the block must stall req while the sender keeps offering.
  initial begin
    int taken;
    int gap;
    bit rx_idle;
    taken         = 0;
    rx_idle       = 1'b0;
    rsp_ch.ready  = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 40 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      if (taken == LONG_STALL_AT) begin
        repeat (LONG_STALL_CYCLES) begin
          @(negedge clk);
          rsp_ch.ready = 1'b0;
        end
      end
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        rsp_ch.ready = 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      taken++;
    end
  end

  // Stimulus: directed corner cases, a forced fill past full, then random
  // segments of varying opcode mix, packet sizes and idling.
  initial begin
    int        sent;
    int        seg_left;
    seg_mode_t mode;
    bit        heavy;
    bit        drained_mid;
    req_ch.valid           = 1'b0;
    req_ch.op              = OP_QUERY;
    req_ch.pkt_size        = '0;
    req_ch.pkt_time        = '0;
    req_ch.processed_value = '0;
    tx_idle                = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue: query, then pops on empty from both ends.
    offer(OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_POP_FRONT, '0, '0, '0);
    offer(OP_POP_BACK, '0, '0, '0);
    // Extreme sizes and stamps from both ends.
    offer(OP_PUSH_BACK, 16'hFFFF, 32'hFFFF_FFFF, '0);
    offer(OP_PUSH_FRONT, 16'h0000, 32'h0000_0000, '0);
    offer(OP_QUERY, '0, '0, '0);
    // Unused opcodes carry live-looking fields; they must change nothing.
    offer(OP_SPARE_6, 16'h5555, 32'h5555_5555, 32'h5555_5555);
    offer(OP_SPARE_7, 16'hAAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    // Processed count at its top, then a front pop wraps it to zero.
    offer(OP_SET_PROC, '0, '0, 32'hFFFF_FFFF);
    offer(OP_POP_FRONT, '0, '0, '0);
    offer(OP_PUSH_BACK, 16'h8000, 32'h8000_0000, '0);
    offer(OP_POP_BACK, '0, '0, '0);
    offer(OP_POP_BACK, '0, '0, '0);
    offer(OP_POP_FRONT, '0, '0, '0);
    offer(OP_SET_PROC, '0, '0, 32'h0000_0001);
    // Short mixed sequence: head and tail move in both directions.
    offer(OP_PUSH_FRONT, 16'h0001, 32'h0000_0001, '0);
    offer(OP_PUSH_FRONT, 16'h0002, 32'h0000_0002, '0);
    offer(OP_PUSH_BACK, 16'h0003, 32'h0000_0003, '0);
    offer(OP_POP_FRONT, '0, '0, '0);
    offer(OP_POP_BACK, '0, '0, '0);
    offer(OP_POP_FRONT, '0, '0, '0);
    offer(OP_SET_PROC, '0, '0, 32'h0000_0000);
    drain_all();

    // Fill past DEPTH with maximum-size packets: reaches full occupancy,
    // then pushes on full must be dropped.
    sent = 0;
    while (sent < FILL_ITEMS) begin
      offer(any_push(), '1, $urandom, $urandom);
      sent++;
    end

    seg_left    = 0;
    mode        = SEG_DRAIN;
    heavy       = 1'b0;
    drained_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        mode     = seg_mode_t'($urandom_range(0, 2));
        heavy    = ($urandom_range(0, 3) == 0);
        tx_idle  = ($urandom_range(0, 2) != 0);
      end
      // Pause once mid-run until every result is back, then resume.
      if (!drained_mid && sent >= MIDRUN_DRAIN_AT) begin
        drained_mid = 1'b1;
        drain_all();
      end
      offer(pick_op(mode), pick_size(heavy), $urandom, pick_count());
      sent++;
      seg_left--;
    end

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
